// ===== hdl/refcounted_clock_source_selector_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the clock source selector
// Wrap concurrent checks on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_CLOCK_SOURCE_SELECTOR_CORE_ASSERT_SVH
`define REFCOUNTED_CLOCK_SOURCE_SELECTOR_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define RCSS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define RCSS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rcss_pkg.sv =====
// ----------------------------------------------------------------------------
// rcss_pkg
// Types and codes shared by the reference-counted clock source selector.
// ----------------------------------------------------------------------------
package rcss_pkg;

  // Command codes
  localparam logic [2:0] CMD_REQ_SLOT  = 3'd0;
  localparam logic [2:0] CMD_REL_SLOT  = 3'd1;
  localparam logic [2:0] CMD_REQ_MIC   = 3'd2;
  localparam logic [2:0] CMD_REL_MIC   = 3'd3;
  localparam logic [2:0] CMD_FORCE_MIC = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ZERO  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // Shared analog bias counter ceiling
  localparam logic [1:0] ANALOG_MAX = 2'd3;

  // Configuration register map
  localparam int unsigned CFG_ADDR_W      = 3;
  localparam logic        REG_IDX_PLL_CNT = 1'b0;
  localparam logic [3:0]  PLL_COUNT_RESET = 4'd4;

  typedef struct packed {
    logic [2:0] command;
    logic [2:0] pll_index;
  } rcss_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       switched;
    logic [3:0] switch_from;
    logic [3:0] switch_to;
    logic       master_clock_on;
    logic       analog_supply_on;
    logic       micbias_on;
  } rcss_out_t;

endpackage

// ===== hdl/refcounted_clock_source_selector_core.sv =====
// Output: each result is registered and appears in the cycle after its command transfer.
// Throughput: one command per cycle while out_ready does not stall the result; the
//   combinational count update and priority pick over the slot counts set that rate.
// Reset (rst_n low, synchronous): all counts and the active source clear,
//   pll_count returns to 4 and the result register empties.
// ----------------------------------------------------------------------------
// refcounted_clock_source_selector_core
// Per-slot use counts, highest-slot clock source pick, mic bias and shared
// analog bias counting, with a registered result and an APB config port.
// ----------------------------------------------------------------------------
`include "refcounted_clock_source_selector_core_assert.svh"

module refcounted_clock_source_selector_core
  import rcss_pkg::*;
#(
  parameter int unsigned PLL_SLOTS  = 4,
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // command channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rcss_in_t              in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output rcss_out_t             out_data,
  // configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int unsigned    SLOT_W    = (PLL_SLOTS > 1) ? $clog2(PLL_SLOTS) : 1;
  localparam logic [3:0]     SLOTS_4   = 4'(PLL_SLOTS);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ZERO  = '0;
  localparam logic [COUNT_BITS-1:0] CNT_ONE   = COUNT_BITS'(1);

  // State
  logic [COUNT_BITS-1:0] cnt_r   [PLL_SLOTS];
  logic [COUNT_BITS-1:0] cnt_nxt [PLL_SLOTS];
  logic [3:0]            active_r, active_nxt;
  logic [1:0]            analog_r, analog_nxt;
  logic [COUNT_BITS-1:0] mic_r, mic_nxt;
  logic [3:0]            pll_count_r;
  logic                  out_valid_r;
  rcss_out_t             out_data_r, res;

  logic                  in_fire, cfg_wr;
  logic [3:0]            limit, idx1, below_next;
  logic                  in_range;
  logic [SLOT_W-1:0]     slot;
  logic [COUNT_BITS-1:0] cur_cnt;
  logic                  a_up, a_down;

  // Handshakes
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Config access
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[CFG_ADDR_W-1] == REG_IDX_PLL_CNT);
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1] == REG_IDX_PLL_CNT)
                      ? {28'd0, pll_count_r} : 32'd0;

  // Address decode for slot commands
  assign limit    = (pll_count_r < SLOTS_4) ? pll_count_r : SLOTS_4;
  assign in_range = ({1'b0, in_data.pll_index} < limit);
  assign idx1     = {1'b0, in_data.pll_index} + 4'd1;
  assign slot     = in_data.pll_index[SLOT_W-1:0];
  assign cur_cnt  = cnt_r[slot];

  // Pick highest busy slot below the addressed one
  always_comb begin
    below_next = 4'd0;
    for (int i = 0; i < PLL_SLOTS; i++) begin
      if ((4'(i) < {1'b0, in_data.pll_index}) && (cnt_r[i] != CNT_ZERO)) begin
        below_next = 4'(i + 1);
      end
    end
  end

  // Command decode and state update
  always_comb begin
    for (int i = 0; i < PLL_SLOTS; i++) begin
      cnt_nxt[i] = cnt_r[i];
    end
    active_nxt      = active_r;
    mic_nxt         = mic_r;
    a_up            = 1'b0;
    a_down          = 1'b0;
    res.status      = ST_OK;
    res.switched    = 1'b0;
    res.switch_from = 4'd0;
    res.switch_to   = 4'd0;
    case (in_data.command)
      CMD_REQ_SLOT: begin
        if (!in_range) begin
          res.status = ST_RANGE;
        end else if (cur_cnt == COUNT_MAX) begin
          res.status = ST_FULL;
        end else begin
          cnt_nxt[slot] = cur_cnt + CNT_ONE;
          if ((cur_cnt == CNT_ZERO) && (idx1 > active_r)) begin
            res.switched    = 1'b1;
            res.switch_from = active_r;
            res.switch_to   = idx1;
            a_up            = (active_r == 4'd0);
            active_nxt      = idx1;
          end
        end
      end
      CMD_REL_SLOT: begin
        if (!in_range) begin
          res.status = ST_RANGE;
        end else if (cur_cnt == CNT_ZERO) begin
          res.status = ST_ZERO;
        end else begin
          cnt_nxt[slot] = cur_cnt - CNT_ONE;
          if ((cur_cnt == CNT_ONE) && (idx1 == active_r)) begin
            res.switched    = 1'b1;
            res.switch_from = active_r;
            res.switch_to   = below_next;
            a_down          = (below_next == 4'd0);
            active_nxt      = below_next;
          end
        end
      end
      CMD_REQ_MIC: begin
        if (mic_r == COUNT_MAX) begin
          res.status = ST_FULL;
        end else begin
          mic_nxt = mic_r + CNT_ONE;
          a_up    = (mic_r == CNT_ZERO);
        end
      end
      CMD_REL_MIC, CMD_FORCE_MIC: begin
        if (mic_r == CNT_ZERO) begin
          res.status = ST_ZERO;
        end else begin
          mic_nxt = (in_data.command == CMD_FORCE_MIC) ? CNT_ZERO : mic_r - CNT_ONE;
          a_down  = (mic_nxt == CNT_ZERO);
        end
      end
      default: begin
      end
    endcase

    // Shared analog bias: saturate up, hold at zero down
    if (a_up) begin
      analog_nxt = (analog_r == ANALOG_MAX) ? analog_r : analog_r + 2'd1;
    end else if (a_down) begin
      analog_nxt = (analog_r == 2'd0) ? analog_r : analog_r - 2'd1;
    end else begin
      analog_nxt = analog_r;
    end

    res.master_clock_on  = (active_nxt != 4'd0);
    res.analog_supply_on = (analog_nxt != 2'd0);
    res.micbias_on       = (mic_nxt != CNT_ZERO);
  end

  // Selector state: advance on each command transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PLL_SLOTS; i++) begin
        cnt_r[i] <= CNT_ZERO;
      end
      active_r <= 4'd0;
      analog_r <= 2'd0;
      mic_r    <= CNT_ZERO;
    end else if (in_fire) begin
      for (int i = 0; i < PLL_SLOTS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
      active_r <= active_nxt;
      analog_r <= analog_nxt;
      mic_r    <= mic_nxt;
    end
  end

  // Config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pll_count_r <= PLL_COUNT_RESET;
    end else if (cfg_wr) begin
      pll_count_r <= cfg_pwdata[3:0];
    end
  end

  // Result register: load on transfer, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res;
    end
  end

  // Checks
  `RCSS_ASSERT_IMP(a_analog_sum, 1'b1,
    analog_r == ({1'b0, active_r != 4'd0} + {1'b0, mic_r != CNT_ZERO}),
    "analog bias count differs from its holders")
  `RCSS_ASSERT_IMP(a_noswitch_zero, out_valid_r && !out_data_r.switched,
    out_data_r.switch_from == 4'd0 && out_data_r.switch_to == 4'd0,
    "switch fields set without a switch")
  `RCSS_ASSERT_IMP(a_switch_moves, out_valid_r && out_data_r.switched,
    out_data_r.switch_from != out_data_r.switch_to && out_data_r.status == ST_OK,
    "switch reported without a move or with an error")
  `RCSS_ASSERT_NXT(a_range_err,
    in_fire && !in_range && (in_data.command == CMD_REQ_SLOT
      || in_data.command == CMD_REL_SLOT),
    out_data_r.status == ST_RANGE && active_r == $past(active_r),
    "out-of-range slot not rejected")

endmodule
